/* sv/bbun_pkg.sv */
// ----------------------------------------------------------------------------
// bbun_pkg
// Shared types and constants for the bounding box unit normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbun_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 8;
	localparam int SCALE_W   = 32;
	localparam int AXES      = 3;

	localparam int NUM_SHIFT = 2 * FRAC_BITS + 1 - GAIN_FRAC;
	localparam int NUM_W     = GAIN_W + NUM_SHIFT;
	localparam int CNT_W     = $clog2(NUM_W + 1);
	localparam int QX_W      = (NUM_W > SCALE_W) ? NUM_W : SCALE_W;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int P_W       = PROD_W - FRAC_BITS;

	localparam logic [COORD_W-1:0] POS_MAX    = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic [COORD_W-1:0] NEG_MIN    = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << FRAC_BITS;
	localparam logic [SCALE_W-1:0] SCALE_MAX  = {SCALE_W{1'b1}};
	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(256);

	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_TRANSFORM = 1'b1;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] norm_x;
		logic signed [COORD_W-1:0] norm_y;
		logic signed [COORD_W-1:0] norm_z;
		logic                      saturated;
		logic                      flat_box;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic measure;
		logic close;
		logic pick;
		logic div_start;
		logic flat_load;
		logic scale_load;
		logic diff;
		logic mul;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic ext_zero;
		logic div_done;
	} dp_stat_t;

endpackage

/* sv/bbun_divider.sv */
// ----------------------------------------------------------------------------
// bbun_divider
// Restoring divider, one quotient bit per cycle, for the fit scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbun_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bbun_pkg::NUM_W-1:0]   dividend,
	input  logic [bbun_pkg::COORD_W-1:0] divisor,
	output logic                         done,
	output logic [bbun_pkg::NUM_W-1:0]   quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [bbun_pkg::CNT_W-1:0]   cnt_q;
	logic [bbun_pkg::COORD_W:0]   rem_q;
	logic [bbun_pkg::NUM_W-1:0]   num_q;
	logic [bbun_pkg::COORD_W-1:0] div_q;
	logic [bbun_pkg::COORD_W:0]   shifted;
	logic                         qbit;

	assign shifted = {rem_q[bbun_pkg::COORD_W-1:0], num_q[bbun_pkg::NUM_W-1]};
	assign qbit    = (shifted >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bbun_pkg::CNT_W'(bbun_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - bbun_pkg::CNT_W'(1);
				if (cnt_q == bbun_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? (shifted - {1'b0, div_q}) : shifted;
			num_q <= {num_q[bbun_pkg::NUM_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

/* sv/bbun_datapath.sv */
// ----------------------------------------------------------------------------
// bbun_datapath
// Box tracking, center and scale registers, transform lanes, output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbun_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bbun_pkg::in_item_t           in_data,
	input  logic                         cfg_we,
	input  logic [bbun_pkg::GAIN_W-1:0]  cfg_data,
	input  bbun_pkg::dp_cmd_t            cmd,
	output bbun_pkg::dp_stat_t           stat,
	output bbun_pkg::out_item_t          out_data
);

	bbun_pkg::in_item_t                  in_s1;
	logic signed [bbun_pkg::COORD_W-1:0] v_s1 [bbun_pkg::AXES];

	logic [bbun_pkg::GAIN_W-1:0]         gain_q;
	logic signed [bbun_pkg::COORD_W-1:0] low_q    [bbun_pkg::AXES];
	logic signed [bbun_pkg::COORD_W-1:0] high_q   [bbun_pkg::AXES];
	logic signed [bbun_pkg::COORD_W-1:0] center_q [bbun_pkg::AXES];
	logic [bbun_pkg::SCALE_W-1:0]        scale_q;
	logic                                closed_q;
	logic                                ext_zero_q;

	logic [bbun_pkg::COORD_W-1:0]        ext_q [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W-1:0]        ext_max_q;

	logic [bbun_pkg::COORD_W-1:0]        mag_s2 [bbun_pkg::AXES];
	logic                                neg_s2 [bbun_pkg::AXES];
	logic [bbun_pkg::PROD_W-1:0]         prod_s3 [bbun_pkg::AXES];
	logic                                neg_s3 [bbun_pkg::AXES];
	bbun_pkg::out_item_t                 out_q;

	logic signed [bbun_pkg::COORD_W-1:0] eff_low  [bbun_pkg::AXES];
	logic signed [bbun_pkg::COORD_W-1:0] eff_high [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W:0]          csum     [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W:0]          cdiff    [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W:0]          vdiff    [bbun_pkg::AXES];
	logic [bbun_pkg::P_W-1:0]            pval     [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W-1:0]        norm     [bbun_pkg::AXES];
	logic                                clip     [bbun_pkg::AXES];
	logic [bbun_pkg::COORD_W-1:0]        max01;
	logic [bbun_pkg::NUM_W-1:0]          dividend;
	logic                                div_done;
	logic [bbun_pkg::NUM_W-1:0]          quotient;
	logic [bbun_pkg::QX_W-1:0]           quot_x;

	localparam logic [bbun_pkg::P_W-1:0] P_POS_LIM = bbun_pkg::P_W'(bbun_pkg::POS_MAX);
	localparam logic [bbun_pkg::P_W-1:0] P_NEG_LIM = bbun_pkg::P_W'(bbun_pkg::NEG_MIN);

	assign v_s1[0] = in_s1.coord_x;
	assign v_s1[1] = in_s1.coord_y;
	assign v_s1[2] = in_s1.coord_z;

	always_comb begin
		for (int a = 0; a < bbun_pkg::AXES; a++) begin
			eff_low[a]  = closed_q ? $signed(bbun_pkg::POS_MAX) : low_q[a];
			eff_high[a] = closed_q ? $signed(bbun_pkg::NEG_MIN) : high_q[a];
			csum[a]     = {low_q[a][bbun_pkg::COORD_W-1], low_q[a]}
				+ {high_q[a][bbun_pkg::COORD_W-1], high_q[a]};
			cdiff[a]    = {high_q[a][bbun_pkg::COORD_W-1], high_q[a]}
				- {low_q[a][bbun_pkg::COORD_W-1], low_q[a]};
			vdiff[a]    = {v_s1[a][bbun_pkg::COORD_W-1], v_s1[a]}
				- {center_q[a][bbun_pkg::COORD_W-1], center_q[a]};
			pval[a]     = prod_s3[a][bbun_pkg::PROD_W-1:bbun_pkg::FRAC_BITS];
			if (neg_s3[a]) begin
				clip[a] = (pval[a] > P_NEG_LIM);
				norm[a] = clip[a] ? bbun_pkg::NEG_MIN
					: bbun_pkg::COORD_W'(0) - pval[a][bbun_pkg::COORD_W-1:0];
			end else begin
				clip[a] = (pval[a] > P_POS_LIM);
				norm[a] = clip[a] ? bbun_pkg::POS_MAX : pval[a][bbun_pkg::COORD_W-1:0];
			end
		end
	end

	assign max01    = (ext_q[1] > ext_q[0]) ? ext_q[1] : ext_q[0];
	assign dividend = bbun_pkg::NUM_W'(gain_q) << bbun_pkg::NUM_SHIFT;
	assign quot_x   = bbun_pkg::QX_W'(quotient);

	bbun_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (ext_max_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// box and fit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= bbun_pkg::GAIN_RESET;
			scale_q    <= bbun_pkg::SCALE_ONE;
			closed_q   <= 1'b0;
			ext_zero_q <= 1'b0;
			for (int a = 0; a < bbun_pkg::AXES; a++) begin
				low_q[a]    <= $signed(bbun_pkg::POS_MAX);
				high_q[a]   <= $signed(bbun_pkg::NEG_MIN);
				center_q[a] <= '0;
			end
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_data;
			end
			if (cmd.measure) begin
				closed_q <= 1'b0;
				for (int a = 0; a < bbun_pkg::AXES; a++) begin
					low_q[a]  <= (v_s1[a] < eff_low[a]) ? v_s1[a] : eff_low[a];
					high_q[a] <= (v_s1[a] > eff_high[a]) ? v_s1[a] : eff_high[a];
				end
			end
			if (cmd.close) begin
				for (int a = 0; a < bbun_pkg::AXES; a++) begin
					center_q[a] <= $signed(csum[a][bbun_pkg::COORD_W:1]);
				end
			end
			if (cmd.flat_load) begin
				scale_q    <= bbun_pkg::SCALE_W'(gain_q) << (bbun_pkg::FRAC_BITS
					- bbun_pkg::GAIN_FRAC);
				ext_zero_q <= 1'b1;
				closed_q   <= 1'b1;
			end
			if (cmd.scale_load) begin
				scale_q    <= (quot_x > bbun_pkg::QX_W'(bbun_pkg::SCALE_MAX))
					? bbun_pkg::SCALE_MAX : quotient[bbun_pkg::SCALE_W-1:0];
				ext_zero_q <= 1'b0;
				closed_q   <= 1'b1;
			end
		end
	end

	// item payload and lanes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_s1 <= in_data;
		end
		if (cmd.close) begin
			for (int a = 0; a < bbun_pkg::AXES; a++) begin
				ext_q[a] <= (high_q[a] > low_q[a]) ? cdiff[a][bbun_pkg::COORD_W-1:0] : '0;
			end
		end
		if (cmd.pick) begin
			ext_max_q <= (ext_q[2] > max01) ? ext_q[2] : max01;
		end
		if (cmd.diff) begin
			for (int a = 0; a < bbun_pkg::AXES; a++) begin
				neg_s2[a] <= vdiff[a][bbun_pkg::COORD_W];
				mag_s2[a] <= vdiff[a][bbun_pkg::COORD_W]
					? bbun_pkg::COORD_W'((bbun_pkg::COORD_W + 1)'(0) - vdiff[a])
					: vdiff[a][bbun_pkg::COORD_W-1:0];
			end
		end
		if (cmd.mul) begin
			for (int a = 0; a < bbun_pkg::AXES; a++) begin
				neg_s3[a]  <= neg_s2[a];
				prod_s3[a] <= bbun_pkg::PROD_W'(mag_s2[a]) * bbun_pkg::PROD_W'(scale_q);
			end
		end
		if (cmd.out_load) begin
			out_q.norm_x    <= norm[0];
			out_q.norm_y    <= norm[1];
			out_q.norm_z    <= norm[2];
			out_q.saturated <= clip[0] | clip[1] | clip[2];
			out_q.flat_box  <= ext_zero_q;
		end
	end

	assign stat.last     = in_s1.last_vertex;
	assign stat.ext_zero = (ext_max_q == '0);
	assign stat.div_done = div_done;
	assign out_data      = out_q;

endmodule

/* sv/bbun_ctrl.sv */
// ----------------------------------------------------------------------------
// bbun_ctrl
// Sequencer for measure, close and transform steps, and the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbun_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bbun_pkg::dp_stat_t stat,
	output bbun_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MEAS,
		S_CLOSE,
		S_PICK,
		S_LAUNCH,
		S_DIV,
		S_DIFF,
		S_MUL
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_wait_q;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !out_wait_q) begin
					cmd.load = 1'b1;
					state_d  = (in_op == bbun_pkg::OP_MEASURE) ? S_MEAS : S_DIFF;
				end
			end
			S_MEAS: begin
				cmd.measure = 1'b1;
				state_d     = stat.last ? S_CLOSE : S_IDLE;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_LAUNCH;
			end
			S_LAUNCH: begin
				if (stat.ext_zero) begin
					cmd.flat_load = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.scale_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (out_wait_q && out_free) begin
			cmd.out_load = 1'b1;
		end
	end

	// out_wait_q marks a finished product waiting for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_MUL) begin
				out_wait_q <= 1'b1;
			end else if (cmd.out_load) begin
				out_wait_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_wait_q;
	assign out_valid = out_valid_q;

endmodule

/* sv/bounding_box_unit_normalizer.sv */
// ----------------------------------------------------------------------------
// bounding_box_unit_normalizer
// Two-pass vertex normalizer: measures the bounding box, then maps vertices
// into the unit cube with a saturated fixed-point scale.
// ----------------------------------------------------------------------------
// measure item: folded into the box; a closing item then waits on the bit-serial
//   divider that forms the scale, skipped when the box is flat
// transform item: result registered in the output stage; items are taken one
//   at a time through the subtract, multiply and saturate steps on one sequencer
// reset: empty box, center zero, scale and gain 1.0, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounding_box_unit_normalizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bbun_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bbun_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bbun_pkg::GAIN_W-1:0] cfg_data
);

	bbun_pkg::dp_cmd_t  cmd;
	bbun_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bbun_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bbun_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

/* verif/bounding_box_unit_normalizer_tb.sv */
// ----------------------------------------------------------------------------
// bounding_box_unit_normalizer_tb
// Self-checking bench for the two-pass vertex normalizer. A directed table
// covers reset values, flat and saturated boxes, center rounding, restarted
// measure passes and tied extents. Random phases follow: each one measures a
// short vertex stream and then replays it as transforms, with noise items and
// unclosed passes mixed in, and the gain is changed between phases while the
// block is idle. Every result is checked against its table entry or a
// fixed-point normalizer model under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounding_box_unit_normalizer_tb;

	localparam longint CMAX       = 64'sd2147483647;
	localparam longint CMIN       = -64'sd2147483648;
	localparam int     RAND_ITEMS = 500;
	localparam int     SETTLE     = 64;
	localparam int     LIMIT      = 500000;

	typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SPARSE} rdy_mode_t;
	typedef enum int {SPAN_FULL, SPAN_NEAR, SPAN_EDGE} span_t;

	typedef struct packed {
		bbun_pkg::in_item_t  vtx;
		logic                typed;
		bbun_pkg::out_item_t want;
	} plan_row_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	bbun_pkg::in_item_t          in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	bbun_pkg::out_item_t         out_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [bbun_pkg::GAIN_W-1:0] cfg_data  = '0;

	longint                       box_lo [bbun_pkg::AXES];
	longint                       box_hi [bbun_pkg::AXES];
	longint                       box_mid [bbun_pkg::AXES];
	logic [bbun_pkg::SCALE_W-1:0] fit_q;
	logic                         box_sealed;
	logic                         flat_q;
	logic [bbun_pkg::GAIN_W-1:0]  gain_q;

	bbun_pkg::out_item_t pending_norm [$];
	plan_row_t           plan [$];
	int                  err_cnt    = 0;
	int unsigned         cycle_cnt  = 0;
	int unsigned         burst_left = 0;
	int unsigned         sent_cnt   = 0;
	rdy_mode_t           rdy_mode   = RDY_ALWAYS;
	int unsigned         rdy_left   = 0;

	bounding_box_unit_normalizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = rdy_mode_t'($urandom_range(0, 3));
			rdy_left = $urandom_range(16, 160);
		end
		rdy_left = rdy_left - 1;
		case (rdy_mode)
			RDY_ALWAYS:   out_ready <= 1'b1;
			RDY_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			RDY_PERIODIC: out_ready <= (rdy_left % 5 == 0);
			default:      out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		bbun_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_norm.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result %h %h %h sat %b flat %b", out_data.norm_x,
						out_data.norm_y, out_data.norm_z, out_data.saturated, out_data.flat_box);
			end else begin
				want = pending_norm.pop_front();
				if (want.norm_x !== out_data.norm_x || want.norm_y !== out_data.norm_y ||
					want.norm_z !== out_data.norm_z || want.saturated !== out_data.saturated ||
					want.flat_box !== out_data.flat_box) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch exp %h %h %h sat %b flat %b got %h %h %h sat %b flat %b",
							want.norm_x, want.norm_y, want.norm_z, want.saturated, want.flat_box,
							out_data.norm_x, out_data.norm_y, out_data.norm_z,
							out_data.saturated, out_data.flat_box);
				end
			end
		end
	end

	function automatic longint axis_of(input bbun_pkg::in_item_t it, input int a);
		case (a)
			0:       return longint'($signed(it.coord_x));
			1:       return longint'($signed(it.coord_y));
			default: return longint'($signed(it.coord_z));
		endcase
	endfunction

	function automatic void restart_extents();
		for (int a = 0; a < bbun_pkg::AXES; a++) begin
			box_lo[a] = CMAX;
			box_hi[a] = CMIN;
		end
	endfunction

	function automatic void seal_box();
		longint      ext_max;
		logic [63:0] quot;
		ext_max = 0;
		for (int a = 0; a < bbun_pkg::AXES; a++) begin
			box_mid[a] = (box_lo[a] + box_hi[a]) >>> 1;
			if (box_hi[a] - box_lo[a] > ext_max)
				ext_max = box_hi[a] - box_lo[a];
		end
		flat_q = (ext_max == 0);
		if (flat_q) begin
			fit_q = bbun_pkg::SCALE_W'(64'(gain_q) << (bbun_pkg::FRAC_BITS
				- bbun_pkg::GAIN_FRAC));
		end else begin
			quot  = (64'(gain_q) << bbun_pkg::NUM_SHIFT) / 64'(ext_max);
			fit_q = (quot > 64'(bbun_pkg::SCALE_MAX)) ? bbun_pkg::SCALE_MAX
				: quot[bbun_pkg::SCALE_W-1:0];
		end
		box_sealed = 1'b1;
	endfunction

	function automatic void measure_vertex(input bbun_pkg::in_item_t it);
		longint v;
		// a measure item after a close starts a fresh box
		if (box_sealed) begin
			box_sealed = 1'b0;
			restart_extents();
		end
		for (int a = 0; a < bbun_pkg::AXES; a++) begin
			v = axis_of(it, a);
			if (v < box_lo[a])
				box_lo[a] = v;
			if (v > box_hi[a])
				box_hi[a] = v;
		end
		if (it.last_vertex)
			seal_box();
	endfunction

	function automatic bbun_pkg::out_item_t normalize_vertex(input bbun_pkg::in_item_t it);
		bbun_pkg::out_item_t res;
		longint              d;
		logic [63:0]         mag;
		logic [63:0]         prod;
		longint              q [bbun_pkg::AXES];
		res = '0;
		for (int a = 0; a < bbun_pkg::AXES; a++) begin
			d    = axis_of(it, a) - box_mid[a];
			mag  = (d < 0) ? 64'(-d) : 64'(d);
			prod = (mag * 64'(fit_q)) >> bbun_pkg::FRAC_BITS;
			if (d < 0) begin
				if (prod > 64'h8000_0000) begin
					res.saturated = 1'b1;
					q[a] = CMIN;
				end else begin
					q[a] = -longint'(prod);
				end
			end else if (prod > 64'h7FFF_FFFF) begin
				res.saturated = 1'b1;
				q[a] = CMAX;
			end else begin
				q[a] = longint'(prod);
			end
		end
		res.norm_x   = bbun_pkg::COORD_W'(q[0]);
		res.norm_y   = bbun_pkg::COORD_W'(q[1]);
		res.norm_z   = bbun_pkg::COORD_W'(q[2]);
		res.flat_box = flat_q;
		return res;
	endfunction

	function automatic void book_vertex(input bbun_pkg::in_item_t it, input logic typed,
		input bbun_pkg::out_item_t want);
		if (it.op == bbun_pkg::OP_MEASURE)
			measure_vertex(it);
		else if (typed)
			pending_norm.insert(pending_norm.size(), want);
		else
			pending_norm.insert(pending_norm.size(), normalize_vertex(it));
	endfunction

	function automatic bbun_pkg::in_item_t vtx(input logic op,
		input logic [bbun_pkg::COORD_W-1:0] x, input logic [bbun_pkg::COORD_W-1:0] y,
		input logic [bbun_pkg::COORD_W-1:0] z, input logic last);
		bbun_pkg::in_item_t it;
		it.op          = op;
		it.coord_x     = x;
		it.coord_y     = y;
		it.coord_z     = z;
		it.last_vertex = last;
		return it;
	endfunction

	function automatic bbun_pkg::out_item_t nrm(input logic [bbun_pkg::COORD_W-1:0] x,
		input logic [bbun_pkg::COORD_W-1:0] y, input logic [bbun_pkg::COORD_W-1:0] z,
		input logic sat, input logic flat);
		bbun_pkg::out_item_t r;
		r.norm_x    = x;
		r.norm_y    = y;
		r.norm_z    = z;
		r.saturated = sat;
		r.flat_box  = flat;
		return r;
	endfunction

	function automatic logic [bbun_pkg::COORD_W-1:0] pick_coord(input span_t span);
		int unsigned roll;
		roll = $urandom_range(0, 3);
		if (span == SPAN_FULL || (span == SPAN_EDGE && roll == 0))
			return $urandom;
		if (span == SPAN_NEAR || roll == 1)
			return bbun_pkg::COORD_W'($urandom_range(0, 1 << 21))
				- bbun_pkg::COORD_W'(1 << 20);
		return (roll == 2) ? bbun_pkg::POS_MAX : bbun_pkg::NEG_MIN;
	endfunction

	function automatic bbun_pkg::in_item_t rand_vertex(input logic op, input span_t span);
		return vtx(op, pick_coord(span), pick_coord(span), pick_coord(span), 1'($urandom));
	endfunction

	task automatic send_vertex(input bbun_pkg::in_item_t it, input logic typed,
		input bbun_pkg::out_item_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
				$urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		book_vertex(it, typed, want);
		sent_cnt++;
	endtask

	// measure items give no result, so a closing divide may still run
	task automatic settle_block();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_norm.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_gain(input logic [bbun_pkg::GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_q = g;
	endtask

	initial begin
		int unsigned                 phase;
		int unsigned                 n_meas;
		span_t                       span;
		bbun_pkg::in_item_t          seen [$];
		bbun_pkg::in_item_t          it;
		logic [bbun_pkg::GAIN_W-1:0] g;

		restart_extents();
		for (int a = 0; a < bbun_pkg::AXES; a++)
			box_mid[a] = 0;
		fit_q      = bbun_pkg::SCALE_ONE;
		box_sealed = 1'b0;
		flat_q     = 1'b0;
		gain_q     = bbun_pkg::GAIN_RESET;

		plan = '{
			// after reset: center zero, scale one
			'{vtx(bbun_pkg::OP_TRANSFORM, 1, -1, bbun_pkg::POS_MAX, 1'b1), 1'b1,
				nrm(1, -1, bbun_pkg::POS_MAX, 1'b0, 1'b0)},
			'{vtx(bbun_pkg::OP_TRANSFORM, bbun_pkg::NEG_MIN, 0, -65536, 1'b0), 1'b1,
				nrm(bbun_pkg::NEG_MIN, 0, -65536, 1'b0, 1'b0)},
			// flat box falls back to the gain
			'{vtx(bbun_pkg::OP_MEASURE, 5, 5, 5, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, 6, 4, 5, 1'b0), 1'b1, nrm(1, -1, 0, 1'b0, 1'b1)},
			// unit extent pins the scale at its ceiling
			'{vtx(bbun_pkg::OP_MEASURE, 0, 0, 0, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_MEASURE, 1, 0, 0, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, bbun_pkg::POS_MAX, bbun_pkg::NEG_MIN, 0, 1'b0), 1'b1,
				nrm(bbun_pkg::POS_MAX, bbun_pkg::NEG_MIN, 0, 1'b1, 1'b0)},
			// new pass keeps the old fit until it closes
			'{vtx(bbun_pkg::OP_MEASURE, bbun_pkg::NEG_MIN, bbun_pkg::NEG_MIN,
				bbun_pkg::POS_MAX, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, 3, 2, 1, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_MEASURE, bbun_pkg::POS_MAX, -3, bbun_pkg::POS_MAX, 1'b0),
				1'b0, '0},
			'{vtx(bbun_pkg::OP_MEASURE, 0, 0, -7, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, bbun_pkg::NEG_MIN, bbun_pkg::POS_MAX, -1, 1'b0),
				1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, 0, 0, 0, 1'b0), 1'b0, '0},
			// odd negative sum rounds the center down
			'{vtx(bbun_pkg::OP_MEASURE, -3, 100, 65536, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_MEASURE, 0, 100, 65536, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, -5, -5, 7, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, -2, 100, 65536, 1'b0), 1'b1,
				nrm(0, 0, 0, 1'b0, 1'b0)},
			// tied extents
			'{vtx(bbun_pkg::OP_MEASURE, 0, 0, 0, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_MEASURE, 4, 4, 4, 1'b1), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, 1, 3, -1, 1'b0), 1'b0, '0},
			'{vtx(bbun_pkg::OP_TRANSFORM, 4, 0, 2, 1'b1), 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_vertex(plan[i].vtx, plan[i].typed, plan[i].want);

		phase    = 0;
		sent_cnt = 0;
		while (sent_cnt < RAND_ITEMS) begin
			if (phase < 4 || $urandom_range(0, 1) == 0) begin
				settle_block();
				case (phase)
					0:       g = '0;
					1:       g = '1;
					2:       g = 1;
					3:       g = bbun_pkg::GAIN_RESET;
					default: g = bbun_pkg::GAIN_W'($urandom);
				endcase
				write_gain(g);
			end
			span = span_t'($urandom_range(0, 2));
			// stray transforms against the previous fit
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3))
					send_vertex(rand_vertex(bbun_pkg::OP_TRANSFORM, span), 1'b0, '0);
			seen.delete();
			n_meas = $urandom_range(1, 8);
			for (int k = 0; k < n_meas; k++) begin
				it = rand_vertex(bbun_pkg::OP_MEASURE, span);
				// now and then the pass is left open or closed early
				it.last_vertex = (k == n_meas - 1) ? ($urandom_range(0, 7) != 0) :
					($urandom_range(0, 15) == 0);
				seen.insert(seen.size(), it);
				send_vertex(it, 1'b0, '0);
			end
			foreach (seen[k]) begin
				it = seen[k];
				it.op = bbun_pkg::OP_TRANSFORM;
				it.last_vertex = 1'($urandom);
				send_vertex(it, 1'b0, '0);
			end
			repeat ($urandom_range(0, 4))
				send_vertex(rand_vertex(bbun_pkg::OP_TRANSFORM, span), 1'b0, '0);
			phase++;
		end

		settle_block();
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
sv/bbun_pkg.sv
sv/bbun_divider.sv
sv/bbun_datapath.sv
sv/bbun_ctrl.sv
sv/bounding_box_unit_normalizer.sv
verif/bounding_box_unit_normalizer_tb.sv
